// ===== rtl/core/gvso_pkg.sv =====
// package: field widths, command codes and register indexes of the separator block
`timescale 1ns / 1ps
`default_nettype none
package gvso_pkg;
   localparam int MAX_VERTICES = 1024;
   localparam int MAX_EDGES = 8192;
   localparam int MAX_PARTS = 16;

   localparam int FUNC_W = 3;
   localparam int INDEX_W = 13;
   localparam int LABEL_W = 4;
   localparam int EDGE_END_W = 14;
   localparam int NBR_W = 10;
   localparam int VALUE_W = 11;
   localparam int VCOUNT_W = 11;
   localparam int PCOUNT_W = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [FUNC_W-1:0] FUNC_LOAD_VERTEX = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_EDGE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_READ_PERM = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ_BLOCK = 3'd4;

   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   localparam logic REG_VERTEX_COUNT = 1'b0;
   localparam logic REG_PART_COUNT = 1'b1;

   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 11'd1;
   localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 5'd1;
endpackage
`default_nettype wire

// ===== rtl/core/gvso_req_if.sv =====
// interface: command channel of the separator block
`timescale 1ns / 1ps
`default_nettype none
interface gvso_req_if;
   logic valid;
   logic ready;
   logic [gvso_pkg::FUNC_W-1:0] func;
   logic [gvso_pkg::INDEX_W-1:0] index;
   logic [gvso_pkg::LABEL_W-1:0] part_label;
   logic [gvso_pkg::EDGE_END_W-1:0] edge_end;
   logic [gvso_pkg::NBR_W-1:0] neighbour;
   modport source (output valid, func, index, part_label, edge_end, neighbour, input ready);
   modport sink (input valid, func, index, part_label, edge_end, neighbour, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/gvso_rsp_if.sv =====
// interface: result channel of the separator block
`timescale 1ns / 1ps
`default_nettype none
interface gvso_rsp_if;
   logic valid;
   logic ready;
   logic [gvso_pkg::VALUE_W-1:0] value;
   logic status;
   modport source (output valid, value, status, input ready);
   modport sink (input valid, value, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/greedy_vertex_separator_ordering_top.sv =====
// top level: graph store, greedy vertex separator sequencer and permutation builder
// One result per command. Loads, block-size reads, flagged commands and unknown commands
// are answered straight from the idle state, a permutation read through one more state
// (registered memory read). Compute is sequenced over registered-read memories: a start
// state, then per vertex a read of its entry and a scan of its adjacency entries with a
// read of each earlier neighbour, a state to close the walk, one to start the build and
// (effective part count + 1) passes to build the permutation. A new command is taken
// once the previous one is done and the result register is free or being emptied.
`timescale 1ns / 1ps
`default_nettype none
module greedy_vertex_separator_ordering_top (
   input wire logic clock,
   input wire logic reset,
   gvso_req_if.sink req_chan,
   gvso_rsp_if.source rsp_chan,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [gvso_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [gvso_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [gvso_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);
   localparam int MAX_VERTICES = gvso_pkg::MAX_VERTICES;
   localparam int MAX_EDGES = gvso_pkg::MAX_EDGES;
   localparam int MAX_PARTS = gvso_pkg::MAX_PARTS;
   localparam int VW = $clog2(MAX_VERTICES);
   localparam int VC = $clog2(MAX_VERTICES + 1);
   localparam int EW = $clog2(MAX_EDGES);
   localparam int EC = $clog2(MAX_EDGES + 1);
   localparam int PC = $clog2(MAX_PARTS + 1);

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_PERM  = 11'b00000000010,
      S_CINIT = 11'b00000000100,
      S_VRD   = 11'b00000001000,
      S_VWT   = 11'b00000010000,
      S_ERD   = 11'b00000100000,
      S_EWT   = 11'b00001000000,
      S_NWT   = 11'b00010000000,
      S_PINIT = 11'b00100000000,
      S_PRD   = 11'b01000000000,
      S_PWT   = 11'b10000000000
   } state_type;

   function automatic logic [EC-1:0] end_clamp(input logic [gvso_pkg::EDGE_END_W-1:0] e);
      if (32'(e) > 32'(MAX_EDGES)) return EC'(MAX_EDGES);
      else return EC'(e);
   endfunction

   function automatic logic [PC-1:0] part_clamp(input logic [gvso_pkg::LABEL_W-1:0] lbl,
                                                input logic [PC-1:0] np);
      if (32'(lbl) >= 32'(np)) return np - 1'b1;
      else return PC'(lbl);
   endfunction

   // memories
   logic [gvso_pkg::LABEL_W-1:0] part_mem [MAX_VERTICES];
   logic [gvso_pkg::EDGE_END_W-1:0] end_mem [MAX_VERTICES];
   logic [gvso_pkg::NBR_W-1:0] adj_mem [MAX_EDGES];
   logic sep_mem [MAX_VERTICES];
   logic [gvso_pkg::NBR_W-1:0] perm_mem [MAX_VERTICES];

   logic [gvso_pkg::LABEL_W-1:0] part_rd;
   logic [gvso_pkg::EDGE_END_W-1:0] end_rd;
   logic [gvso_pkg::NBR_W-1:0] adj_rd;
   logic sep_rd;
   logic [gvso_pkg::NBR_W-1:0] perm_rd;

   logic part_we, adj_we, sep_we, perm_we;
   logic [VW-1:0] part_wa, part_ra, end_ra, sep_wa, sep_ra, perm_wa, perm_ra;
   logic [EW-1:0] adj_wa, adj_ra;
   logic sep_wd;

   state_type state_ff, state_in;
   logic [gvso_pkg::VCOUNT_W-1:0] vertex_count_ff, vertex_count_in;
   logic [gvso_pkg::PCOUNT_W-1:0] part_count_ff, part_count_in;
   logic [VC-1:0] v_ff, v_in, cnt_ff, cnt_in, pos_ff, pos_in, perm_len_ff, perm_len_in;
   logic [EC-1:0] prev_end_ff, prev_end_in, end_ff, end_in, j_ff, j_in;
   logic [PC-1:0] pv_ff, pv_in, p_ff, p_in;
   logic sep_cur_ff, sep_cur_in;
   logic [VC-1:0] bs_ff [MAX_PARTS+1];
   logic bs_clear, bs_we;
   logic rsp_valid_ff, rsp_valid_in;
   logic [gvso_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic rsp_status_ff, rsp_status_in;

   logic [VC-1:0] n_eff;
   logic [PC-1:0] np_eff;
   logic out_free, accept, csr_write, match;

   always_comb begin
      if (32'(vertex_count_ff) > 32'(MAX_VERTICES)) n_eff = VC'(MAX_VERTICES);
      else n_eff = VC'(vertex_count_ff);
      if (part_count_ff == '0) np_eff = PC'(1);
      else if (32'(part_count_ff) > 32'(MAX_PARTS)) np_eff = PC'(MAX_PARTS);
      else np_eff = PC'(part_count_ff);
   end

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      vertex_count_in = vertex_count_ff;
      part_count_in = part_count_ff;
      if (csr_write) begin
         if (csr_paddr[2] == gvso_pkg::REG_VERTEX_COUNT) begin
            vertex_count_in = csr_pwdata[gvso_pkg::VCOUNT_W-1:0];
         end else begin
            part_count_in = csr_pwdata[gvso_pkg::PCOUNT_W-1:0];
         end
      end
      if (csr_paddr[2] == gvso_pkg::REG_VERTEX_COUNT) begin
         csr_prdata = 32'(vertex_count_ff);
      end else begin
         csr_prdata = 32'(part_count_ff);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && out_free;
   assign accept = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.value = rsp_value_ff;
   assign rsp_chan.status = rsp_status_ff;

   always_comb begin
      if (p_ff == np_eff) match = sep_rd;
      else match = !sep_rd && (part_clamp(part_rd, np_eff) == p_ff);
   end

   always_comb begin
      state_in = state_ff;
      v_in = v_ff;
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      perm_len_in = perm_len_ff;
      prev_end_in = prev_end_ff;
      end_in = end_ff;
      j_in = j_ff;
      pv_in = pv_ff;
      p_in = p_ff;
      sep_cur_in = sep_cur_ff;
      bs_clear = 1'b0;
      bs_we = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      part_we = 1'b0;
      adj_we = 1'b0;
      sep_we = 1'b0;
      perm_we = 1'b0;
      part_wa = VW'(req_chan.index);
      adj_wa = EW'(req_chan.index);
      part_ra = v_ff[VW-1:0];
      end_ra = v_ff[VW-1:0];
      adj_ra = j_ff[EW-1:0];
      sep_ra = v_ff[VW-1:0];
      sep_wa = v_ff[VW-1:0];
      sep_wd = sep_cur_ff;
      perm_wa = pos_ff[VW-1:0];
      perm_ra = VW'(req_chan.index);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_value_in = '0;
               rsp_status_in = gvso_pkg::STATUS_OK;
               rsp_valid_in = 1'b1;
               case (req_chan.func)
                  gvso_pkg::FUNC_LOAD_VERTEX: begin
                     if (32'(req_chan.index) < 32'(MAX_VERTICES)) part_we = 1'b1;
                     else rsp_status_in = gvso_pkg::STATUS_RANGE;
                  end
                  gvso_pkg::FUNC_LOAD_EDGE: begin
                     if (32'(req_chan.index) < 32'(MAX_EDGES)) adj_we = 1'b1;
                     else rsp_status_in = gvso_pkg::STATUS_RANGE;
                  end
                  gvso_pkg::FUNC_COMPUTE: begin
                     rsp_valid_in = 1'b0;
                     state_in = S_CINIT;
                  end
                  gvso_pkg::FUNC_READ_PERM: begin
                     if (32'(req_chan.index) < 32'(perm_len_ff)) begin
                        rsp_valid_in = 1'b0;
                        state_in = S_PERM;
                     end else begin
                        rsp_status_in = gvso_pkg::STATUS_RANGE;
                     end
                  end
                  gvso_pkg::FUNC_READ_BLOCK: begin
                     if (32'(req_chan.index) <= 32'(np_eff)) begin
                        rsp_value_in = gvso_pkg::VALUE_W'(bs_ff[PC'(req_chan.index)]);
                     end else begin
                        rsp_status_in = gvso_pkg::STATUS_RANGE;
                     end
                  end
                  default: rsp_status_in = gvso_pkg::STATUS_RANGE;
               endcase
            end
         end
         S_PERM: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = gvso_pkg::VALUE_W'(perm_rd);
            rsp_status_in = gvso_pkg::STATUS_OK;
            state_in = S_IDLE;
         end
         S_CINIT: begin
            bs_clear = 1'b1;
            v_in = '0;
            prev_end_in = '0;
            pos_in = '0;
            state_in = S_VRD;
         end
         S_VRD: begin
            if (v_ff == n_eff) state_in = S_PINIT;
            else state_in = S_VWT;
         end
         S_VWT: begin
            pv_in = part_clamp(part_rd, np_eff);
            end_in = end_clamp(end_rd);
            prev_end_in = end_clamp(end_rd);
            j_in = prev_end_ff;
            sep_cur_in = 1'b0;
            state_in = S_ERD;
         end
         S_ERD: begin
            if (j_ff >= end_ff || sep_cur_ff) begin
               sep_we = 1'b1;
               v_in = v_ff + 1'b1;
               state_in = S_VRD;
            end else begin
               state_in = S_EWT;
            end
         end
         S_EWT: begin
            j_in = j_ff + 1'b1;
            part_ra = VW'(adj_rd);
            sep_ra = VW'(adj_rd);
            if (32'(adj_rd) < 32'(v_ff)) state_in = S_NWT;
            else state_in = S_ERD;
         end
         S_NWT: begin
            if (part_clamp(part_rd, np_eff) != pv_ff && !sep_rd) sep_cur_in = 1'b1;
            state_in = S_ERD;
         end
         S_PINIT: begin
            p_in = '0;
            v_in = '0;
            cnt_in = '0;
            state_in = S_PRD;
         end
         S_PRD: begin
            if (v_ff == n_eff) begin
               bs_we = 1'b1;
               v_in = '0;
               cnt_in = '0;
               if (p_ff == np_eff) begin
                  perm_len_in = pos_ff;
                  rsp_valid_in = 1'b1;
                  rsp_value_in = '0;
                  rsp_status_in = gvso_pkg::STATUS_OK;
                  state_in = S_IDLE;
               end else begin
                  p_in = p_ff + 1'b1;
               end
            end else begin
               state_in = S_PWT;
            end
         end
         S_PWT: begin
            if (match) begin
               perm_we = 1'b1;
               pos_in = pos_ff + 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
            perm_wa = pos_ff[VW-1:0];
            v_in = v_ff + 1'b1;
            state_in = S_PRD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vertex_count_ff <= gvso_pkg::VCOUNT_RESET;
         part_count_ff <= gvso_pkg::PCOUNT_RESET;
         perm_len_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i <= MAX_PARTS; i++) bs_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         vertex_count_ff <= vertex_count_in;
         part_count_ff <= part_count_in;
         perm_len_ff <= perm_len_in;
         rsp_valid_ff <= rsp_valid_in;
         if (bs_clear) begin
            for (int i = 0; i <= MAX_PARTS; i++) bs_ff[i] <= '0;
         end else if (bs_we) begin
            bs_ff[p_ff] <= cnt_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      cnt_ff <= cnt_in;
      pos_ff <= pos_in;
      prev_end_ff <= prev_end_in;
      end_ff <= end_in;
      j_ff <= j_in;
      pv_ff <= pv_in;
      p_ff <= p_in;
      sep_cur_ff <= sep_cur_in;
      rsp_value_ff <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // vertex stores
   always_ff @(posedge clock) begin
      if (part_we) begin
         part_mem[part_wa] <= req_chan.part_label;
         end_mem[part_wa] <= req_chan.edge_end;
      end
      part_rd <= part_mem[part_ra];
      end_rd <= end_mem[end_ra];
   end

   // adjacency store
   always_ff @(posedge clock) begin
      if (adj_we) adj_mem[adj_wa] <= req_chan.neighbour;
      adj_rd <= adj_mem[adj_ra];
   end

   // separator flags, written once per vertex in order
   always_ff @(posedge clock) begin
      if (sep_we) sep_mem[sep_wa] <= sep_wd;
      sep_rd <= sep_mem[sep_ra];
   end

   // permutation store
   always_ff @(posedge clock) begin
      if (perm_we) perm_mem[perm_wa] <= gvso_pkg::NBR_W'(v_ff);
      perm_rd <= perm_mem[perm_ra];
   end
endmodule
`default_nettype wire

// ===== rtl/core/gvso_checker.sv =====
// checker: port-level properties of the separator block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module gvso_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic [gvso_pkg::FUNC_W-1:0] req_func,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [gvso_pkg::VALUE_W-1:0] rsp_value,
   input wire logic rsp_status
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid || rsp_ready)
      else $error("command taken while result register blocked");

   a_load_reply: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == gvso_pkg::FUNC_LOAD_VERTEX ||
      req_func == gvso_pkg::FUNC_LOAD_EDGE) |=> rsp_valid)
      else $error("load without result");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_value == '0)
      else $error("flagged result carries data");
endmodule

bind greedy_vertex_separator_ordering_top gvso_checker u_gvso_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .req_func(req_chan.func),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_value(rsp_chan.value),
   .rsp_status(rsp_chan.status)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
// testbench: greedy vertex separator block, checked against a behavioural predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   localparam int NV = gvso_pkg::MAX_VERTICES;
   localparam int NE = gvso_pkg::MAX_EDGES;
   localparam int NP = gvso_pkg::MAX_PARTS;

   typedef struct packed {
      logic [gvso_pkg::VALUE_W-1:0] value;
      logic status;
   } result_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [gvso_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [gvso_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [gvso_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   gvso_req_if req_chan();
   gvso_rsp_if rsp_chan();

   greedy_vertex_separator_ordering_top u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // graph and ordering state as the block should hold it
   logic [gvso_pkg::LABEL_W-1:0] g_part[NV];
   logic [gvso_pkg::EDGE_END_W-1:0] g_end[NV];
   logic [gvso_pkg::NBR_W-1:0] g_adj[NE];
   bit g_sep[NV];
   logic [gvso_pkg::NBR_W-1:0] g_perm[NV];
   int g_blk[NP+1];
   int g_perm_len;
   int g_vcount, g_pcount;
   bit vtx_written[NV];
   bit edge_written[NE];

   result_type pending_results[$];
   int sender_idle_pct, receiver_stall_pct;
   int errors, cmds_sent, results_seen, computes_run;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("tb_top failed");
      $finish;
   end

   function automatic int vcount_eff();
      return g_vcount > NV ? NV : g_vcount;
   endfunction

   function automatic int pcount_eff();
      if (g_pcount == 0) return 1;
      return g_pcount > NP ? NP : g_pcount;
   endfunction

   function automatic int part_in(int v, int np);
      return g_part[v] >= np ? np - 1 : int'(g_part[v]);
   endfunction

   function automatic int end_clamped(int e);
      return e > NE ? NE : e;
   endfunction

   function automatic void build_separator();
      int n, np, first, last, nb, pos, cnt, nsep;
      n = vcount_eff();
      np = pcount_eff();
      pos = 0;
      nsep = 0;
      foreach (g_sep[i]) g_sep[i] = 0;
      foreach (g_blk[i]) g_blk[i] = 0;
      for (int v = 0; v < n; v++) begin
         first = v == 0 ? 0 : end_clamped(g_end[v-1]);
         last = end_clamped(g_end[v]);
         for (int j = first; j < last && !g_sep[v]; j++) begin
            nb = g_adj[j];
            if (nb < v && part_in(nb, np) != part_in(v, np) && !g_sep[nb]) g_sep[v] = 1;
         end
      end
      for (int p = 0; p < np; p++) begin
         cnt = 0;
         for (int v = 0; v < n; v++)
            if (!g_sep[v] && part_in(v, np) == p) begin
               g_perm[pos++] = gvso_pkg::NBR_W'(v);
               cnt++;
            end
         g_blk[p] = cnt;
      end
      for (int v = 0; v < n; v++)
         if (g_sep[v]) begin
            g_perm[pos++] = gvso_pkg::NBR_W'(v);
            nsep++;
         end
      g_blk[np] = nsep;
      g_perm_len = pos;
   endfunction

   function automatic result_type predict_result(logic [gvso_pkg::FUNC_W-1:0] f,
                                                 logic [gvso_pkg::INDEX_W-1:0] idx,
                                                 logic [gvso_pkg::LABEL_W-1:0] lbl,
                                                 logic [gvso_pkg::EDGE_END_W-1:0] e,
                                                 logic [gvso_pkg::NBR_W-1:0] nb);
      result_type r;
      r = '0;
      case (f)
         gvso_pkg::FUNC_LOAD_VERTEX: begin
            if (idx < NV) begin
               g_part[idx] = lbl;
               g_end[idx] = e;
               vtx_written[idx] = 1;
            end else r.status = gvso_pkg::STATUS_RANGE;
         end
         gvso_pkg::FUNC_LOAD_EDGE: begin
            g_adj[idx] = nb;
            edge_written[idx] = 1;
         end
         gvso_pkg::FUNC_COMPUTE: build_separator();
         gvso_pkg::FUNC_READ_PERM: begin
            if (idx < g_perm_len) r.value = gvso_pkg::VALUE_W'(g_perm[idx]);
            else r.status = gvso_pkg::STATUS_RANGE;
         end
         gvso_pkg::FUNC_READ_BLOCK: begin
            if (idx <= pcount_eff()) r.value = gvso_pkg::VALUE_W'(g_blk[idx]);
            else r.status = gvso_pkg::STATUS_RANGE;
         end
         default: r.status = gvso_pkg::STATUS_RANGE;
      endcase
      return r;
   endfunction

   task automatic send_cmd(int f, int idx, int lbl = 0, int e = 0, int nb = 0);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.func <= gvso_pkg::FUNC_W'(f);
      req_chan.index <= gvso_pkg::INDEX_W'(idx);
      req_chan.part_label <= gvso_pkg::LABEL_W'(lbl);
      req_chan.edge_end <= gvso_pkg::EDGE_END_W'(e);
      req_chan.neighbour <= gvso_pkg::NBR_W'(nb);
      do @(posedge clock); while (!req_chan.ready);
      pending_results = {pending_results,
                         predict_result(gvso_pkg::FUNC_W'(f), gvso_pkg::INDEX_W'(idx),
                                        gvso_pkg::LABEL_W'(lbl), gvso_pkg::EDGE_END_W'(e),
                                        gvso_pkg::NBR_W'(nb))};
      cmds_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [gvso_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (idx == gvso_pkg::REG_VERTEX_COUNT) g_vcount = data[gvso_pkg::VCOUNT_W-1:0];
      else g_pcount = data[gvso_pkg::PCOUNT_W-1:0];
   endtask

   task automatic configure(int vc, int pc);
      drain();
      csr_write(gvso_pkg::REG_VERTEX_COUNT, vc);
      csr_write(gvso_pkg::REG_PART_COUNT, pc);
   endtask

   // loads whatever the compute walk would touch but was never written, then computes
   task automatic run_compute();
      int n, first, last;
      n = vcount_eff();
      for (int v = 0; v < n; v++)
         if (!vtx_written[v])
            send_cmd(gvso_pkg::FUNC_LOAD_VERTEX, v, $urandom_range(0, 15),
                     v == 0 ? 0 : int'(g_end[v-1]));
      for (int v = 0; v < n; v++) begin
         first = v == 0 ? 0 : end_clamped(g_end[v-1]);
         last = end_clamped(g_end[v]);
         for (int j = first; j < last; j++)
            if (!edge_written[j])
               send_cmd(gvso_pkg::FUNC_LOAD_EDGE, j, 0, 0, $urandom_range(0, n));
      end
      send_cmd(gvso_pkg::FUNC_COMPUTE, $urandom_range(0, 8191));
      computes_run++;
   endtask

   task automatic read_back(int perm_reads, int blk_reads);
      repeat (perm_reads)
         send_cmd(gvso_pkg::FUNC_READ_PERM, $urandom_range(0, g_perm_len + 2));
      repeat (blk_reads)
         send_cmd(gvso_pkg::FUNC_READ_BLOCK, $urandom_range(0, pcount_eff() + 2));
      if ($urandom_range(0, 3) == 0)
         send_cmd(gvso_pkg::FUNC_READ_PERM, $urandom_range(0, 8191));
   endtask

   task automatic test_reset_state();
      send_cmd(gvso_pkg::FUNC_READ_PERM, 0);
      send_cmd(gvso_pkg::FUNC_READ_BLOCK, 0);
      send_cmd(gvso_pkg::FUNC_READ_BLOCK, 1);
      send_cmd(gvso_pkg::FUNC_READ_BLOCK, 2);
      send_cmd(gvso_pkg::FUNC_LOAD_VERTEX, NV, 15, -1);
      send_cmd(gvso_pkg::FUNC_LOAD_VERTEX, 8191, 15, -1);
      for (int f = gvso_pkg::FUNC_READ_BLOCK + 1; f < 8; f++) send_cmd(f, 8191, 15, -1, -1);
   endtask

   // self-loop, separator neighbour skipped, oversized label, reversed edge range
   task automatic test_special_graph();
      configure(5, 2);
      send_cmd(gvso_pkg::FUNC_LOAD_VERTEX, 0, 0, 1);
      send_cmd(gvso_pkg::FUNC_LOAD_VERTEX, 1, 1, 3);
      send_cmd(gvso_pkg::FUNC_LOAD_VERTEX, 2, 15, 5);
      send_cmd(gvso_pkg::FUNC_LOAD_VERTEX, 3, 0, 4);
      send_cmd(gvso_pkg::FUNC_LOAD_VERTEX, 4, 0, 6);
      send_cmd(gvso_pkg::FUNC_LOAD_EDGE, 0, 0, 0, 0);
      send_cmd(gvso_pkg::FUNC_LOAD_EDGE, 1, 0, 0, 0);
      send_cmd(gvso_pkg::FUNC_LOAD_EDGE, 2, 0, 0, 1);
      send_cmd(gvso_pkg::FUNC_LOAD_EDGE, 3, 0, 0, 1);
      send_cmd(gvso_pkg::FUNC_LOAD_EDGE, 4, 0, 0, 0);
      send_cmd(gvso_pkg::FUNC_LOAD_EDGE, 8191, 0, 0, 1023);
      run_compute();
      for (int i = 0; i < 6; i++) send_cmd(gvso_pkg::FUNC_READ_PERM, i);
      for (int i = 0; i < 4; i++) send_cmd(gvso_pkg::FUNC_READ_BLOCK, i);
   endtask

   // empty graph, register wrap at the field width and part count saturation
   task automatic test_register_extremes();
      configure(0, 0);
      run_compute();
      send_cmd(gvso_pkg::FUNC_READ_PERM, 0);
      for (int i = 0; i < 3; i++) send_cmd(gvso_pkg::FUNC_READ_BLOCK, i);
      configure(2048 + 6, 31);
      for (int v = 0; v < 6; v++)
         send_cmd(gvso_pkg::FUNC_LOAD_VERTEX, v, $urandom_range(0, 15), v);
      run_compute();
      for (int i = 0; i <= 6; i++) send_cmd(gvso_pkg::FUNC_READ_PERM, i);
      for (int i = 0; i <= NP + 1; i++) send_cmd(gvso_pkg::FUNC_READ_BLOCK, i);
      configure(6, 16);
      run_compute();
      read_back(4, 4);
   endtask

   task automatic test_random_graphs(int quota);
      int stop_at, n, e;
      stop_at = cmds_sent + quota;
      while (cmds_sent < stop_at) begin
         n = $urandom_range(0, 9) == 0 ? $urandom_range(25, 64) : $urandom_range(1, 24);
         configure(n, $urandom_range(0, 4) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 5));
         e = 0;
         for (int v = 0; v < n; v++) begin
            if ($urandom_range(0, 19) == 0) e = $urandom_range(0, e);
            else e += $urandom_range(0, 4);
            send_cmd(gvso_pkg::FUNC_LOAD_VERTEX, v, $urandom_range(0, 15), e);
            if ($urandom_range(0, 29) == 0)
               send_cmd(gvso_pkg::FUNC_LOAD_VERTEX, $urandom_range(NV, 8191),
                        $urandom_range(0, 15), $urandom_range(0, 16383));
         end
         for (int j = 0; j < e; j++) begin
            send_cmd(gvso_pkg::FUNC_LOAD_EDGE, j, 0, 0,
                     $urandom_range(0, 9) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, n));
            if ($urandom_range(0, 29) == 0)
               send_cmd($urandom_range(5, 7), $urandom_range(0, 8191));
         end
         run_compute();
         read_back($urandom_range(2, 8), $urandom_range(1, 4));
      end
   endtask

   always @(negedge clock)
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= $urandom_range(0, 99) >= receiver_stall_pct;

   always @(posedge clock)
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected transfer value %0d status %0d", $time,
                     rsp_chan.value, rsp_chan.status);
            errors++;
         end else begin
            result_type want;
            want = pending_results.pop_front();
            if (want.value !== rsp_chan.value || want.status !== rsp_chan.status) begin
               $display("%0t: expected value %0d status %0d, got value %0d status %0d", $time,
                        want.value, want.status, rsp_chan.value, rsp_chan.status);
               errors++;
            end
         end
      end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.func = '0;
      req_chan.index = '0;
      req_chan.part_label = '0;
      req_chan.edge_end = '0;
      req_chan.neighbour = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      errors = 0;
      cmds_sent = 0;
      results_seen = 0;
      computes_run = 0;
      g_vcount = gvso_pkg::VCOUNT_RESET;
      g_pcount = gvso_pkg::PCOUNT_RESET;
      g_perm_len = 0;
      foreach (g_part[i]) g_part[i] = '0;
      foreach (g_end[i]) g_end[i] = '0;
      foreach (g_adj[i]) g_adj[i] = '0;
      foreach (g_sep[i]) g_sep[i] = 0;
      foreach (g_perm[i]) g_perm[i] = '0;
      foreach (g_blk[i]) g_blk[i] = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_special_graph();
      test_register_extremes();
      test_random_graphs(100);
      sender_idle_pct = 73;
      test_random_graphs(100);
      sender_idle_pct = 0;
      receiver_stall_pct = 73;
      test_random_graphs(100);
      sender_idle_pct = 19;
      receiver_stall_pct = 19;
      test_random_graphs(100);
      drain();

      $display("%0d commands, %0d computes, %0d results checked", cmds_sent, computes_run,
               results_seen);
      $display("covered loads, range flags, unknown commands, register extremes and idling");
      if (errors == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end
endmodule
`default_nettype wire
